FILE: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define WLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define WLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wls_pkg;

    localparam int WINDOW      = 256;
    localparam int CHANNELS    = 7;
    localparam int SAMPLE_BITS = 32;

    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int META_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RING_D  = CHANNELS * WINDOW;
    localparam int RING_AW = $clog2(RING_D);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [RING_AW-1:0]     t_ring_addr;
    typedef logic [META_AW-1:0]     t_meta_addr;

    typedef enum logic [1:0] {
        FN_RECORD = 2'd0,
        FN_CLEAR  = 2'd1,
        FN_QUERY  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_META,
        ST_CAND_RD,
        ST_CAND_WAIT,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic [IDX_W-1:0] wp;
        logic [31:0]      total;
        t_sample          peak;
        t_sample          latest;
    } t_meta;

    typedef struct packed {
        logic       we;
        logic       clr;
        t_meta_addr addr;
        t_meta      data;
    } t_meta_wr;

    typedef struct packed {
        logic       we;
        t_ring_addr addr;
        t_sample    data;
    } t_ring_wr;

    typedef struct packed {
        logic        stats_valid;
        logic [31:0] total_count;
        logic [31:0] max_value;
        logic [31:0] last_value;
        logic [31:0] median_value;
    } t_result;

endpackage

`default_nettype wire

FILE: design/wls_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wls_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  channel;
    logic [31:0] sample_us;

    modport source (output valid, output func, output channel, output sample_us,
                    input ready);
    modport sink   (input valid, input func, input channel, input sample_us,
                    output ready);
endinterface

interface wls_out_if;
    logic        valid;
    logic        ready;
    logic        stats_valid;
    logic [31:0] total_count;
    logic [31:0] max_value;
    logic [31:0] last_value;
    logic [31:0] median_value;

    modport source (output valid, output stats_valid, output total_count,
                    output max_value, output last_value, output median_value,
                    input ready);
    modport sink   (input valid, input stats_valid, input total_count,
                    input max_value, input last_value, input median_value,
                    output ready);
endinterface

`default_nettype wire

FILE: design/windowed_latency_stats_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    func, channel, sample_us
// o_out     out  valid/ready    stats_valid, total_count, max_value, last_value,
//                               median_value
//
// Record and clear update the channel in ST_META, then go idle; a query of an
// empty or unknown channel goes from ST_META to ST_EMIT. A median query walks the
// ring through its single read port, comparing each candidate with the window.
// Synchronous active-low reset clears control state and the channel valid bits;
// the sample ring needs no clearing pass.
// A query waits in its last state while the output register is still full.

module windowed_latency_stats_core (
    input  wire   i_clk,
    input  wire   i_rst_n,
    wls_in_if.sink    i_in,
    wls_out_if.source o_out
);
    import wls_pkg::*;

    t_state r_state, n_state;

    logic [1:0]       r_func;
    logic [2:0]       r_ch;
    logic             r_ok;
    t_sample          r_smp;
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [CNT_W-1:0] r_less;
    logic [CNT_W-1:0] r_same;
    t_sample          r_cand;
    t_result          r_res;
    logic             r_ov;
    t_result          r_odata;

    t_meta      meta;
    t_meta      meta_upd;
    t_meta_wr   meta_wr;
    t_meta_addr meta_rd_addr;
    t_ring_wr   ring_wr;
    t_ring_addr ring_rd_addr;
    t_ring_addr ring_base;
    t_sample    ring_rd;

    logic [CNT_W-1:0] less_n, same_n, kpos;
    logic             last_j, last_i, hit, in_ok, out_free;

    wls_meta_mem u_meta (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (meta_wr),
        .i_rd_addr (meta_rd_addr),
        .o_rd_data (meta)
    );

    wls_ring_mem u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_rd_addr (ring_rd_addr),
        .o_rd_data (ring_rd)
    );

    assign in_ok     = 32'(i_in.channel) < CHANNELS;
    assign out_free  = !r_ov || o_out.ready;
    assign ring_base = RING_AW'(r_ch) * RING_AW'(WINDOW);

    // compare counts including the word arriving this cycle
    assign less_n = r_less + CNT_W'(ring_rd < r_cand);
    assign same_n = r_same + CNT_W'(ring_rd == r_cand);
    assign kpos   = r_fill >> 1;
    assign last_j = r_j == IDX_W'(r_fill - CNT_W'(1));
    assign last_i = r_i == IDX_W'(r_fill - CNT_W'(1));
    assign hit    = (less_n <= kpos) && (kpos < less_n + same_n);

    always_comb begin
        meta_upd        = meta;
        meta_upd.fill   = (meta.fill == CNT_W'(WINDOW)) ? meta.fill
                                                        : meta.fill + CNT_W'(1);
        meta_upd.wp     = (meta.wp == IDX_W'(WINDOW - 1)) ? '0 : meta.wp + IDX_W'(1);
        meta_upd.total  = meta.total + 32'd1;
        meta_upd.latest = r_smp;
        meta_upd.peak   = (r_smp > meta.peak) ? r_smp : meta.peak;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_META;
            end
            ST_META: begin
                case (r_func)
                    FN_QUERY: n_state = (!r_ok || meta.fill == '0) ? ST_EMIT : ST_CAND_RD;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_CAND_RD:   n_state = ST_CAND_WAIT;
            ST_CAND_WAIT: n_state = ST_SCAN;
            ST_SCAN: begin
                if (last_j) n_state = (hit || last_i) ? ST_EMIT : ST_CAND_RD;
            end
            ST_EMIT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready   = (r_state == ST_IDLE);
        meta_rd_addr = in_ok ? META_AW'(i_in.channel) : '0;
        meta_wr      = '0;
        ring_wr      = '0;
        ring_rd_addr = ring_base;
        case (r_state)
            ST_META: begin
                if (r_ok && r_func == FN_RECORD) begin
                    meta_wr.we   = 1'b1;
                    meta_wr.addr = META_AW'(r_ch);
                    meta_wr.data = meta_upd;
                    ring_wr.we   = 1'b1;
                    ring_wr.addr = ring_base + RING_AW'(meta.wp);
                    ring_wr.data = r_smp;
                end else if (r_ok && r_func == FN_CLEAR) begin
                    meta_wr.we   = 1'b1;
                    meta_wr.clr  = 1'b1;
                    meta_wr.addr = META_AW'(r_ch);
                end
            end
            ST_CAND_RD: ring_rd_addr = ring_base + RING_AW'(r_i);
            ST_SCAN:    ring_rd_addr = ring_base + RING_AW'(IDX_W'(r_j + IDX_W'(1)));
            default:    ring_rd_addr = ring_base;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMIT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    r_func <= i_in.func;
                    r_ch   <= i_in.channel;
                    r_ok   <= in_ok;
                    r_smp  <= SAMPLE_BITS'(i_in.sample_us);
                end
            end
            ST_META: begin
                r_fill <= meta.fill;
                r_i    <= '0;
                r_res  <= '0;
                if (r_ok) begin
                    r_res.total_count <= meta.total;
                    r_res.max_value   <= 32'(meta.peak);
                    r_res.last_value  <= 32'(meta.latest);
                end
            end
            ST_CAND_WAIT: begin
                r_cand <= ring_rd;
                r_j    <= '0;
                r_less <= '0;
                r_same <= '0;
            end
            ST_SCAN: begin
                r_less <= less_n;
                r_same <= same_n;
                r_j    <= r_j + IDX_W'(1);
                if (last_j) begin
                    r_i <= r_i + IDX_W'(1);
                    if (hit) begin
                        r_res.stats_valid  <= 1'b1;
                        r_res.median_value <= 32'(r_cand);
                    end else if (last_i) begin
                        r_res.stats_valid  <= 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) r_odata <= r_res;
            end
            default: ;
        endcase
    end

    assign o_out.valid        = r_ov;
    assign o_out.stats_valid  = r_odata.stats_valid;
    assign o_out.total_count  = r_odata.total_count;
    assign o_out.max_value    = r_odata.max_value;
    assign o_out.last_value   = r_odata.last_value;
    assign o_out.median_value = r_odata.median_value;

endmodule

`default_nettype wire

FILE: design/wls_ring_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module wls_ring_mem (
    input  wire                   i_clk,
    input  wls_pkg::t_ring_wr     i_wr,
    input  wls_pkg::t_ring_addr   i_rd_addr,
    output wls_pkg::t_sample      o_rd_data
);
    import wls_pkg::*;

    t_sample mem [RING_D];
    t_sample r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

FILE: design/wls_meta_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module wls_meta_mem (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wls_pkg::t_meta_wr     i_wr,
    input  wls_pkg::t_meta_addr   i_rd_addr,
    output wls_pkg::t_meta        o_rd_data
);
    import wls_pkg::*;

    t_meta                mem [CHANNELS];
    logic [CHANNELS-1:0]  r_vld;
    t_meta                r_rd;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.we && !i_wr.clr) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= mem[i_rd_addr];
    end

    // an entry without its valid bit reads as the cleared state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_wr.addr] <= !i_wr.clr;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

`default_nettype wire

FILE: design/wls_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wls_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_stats_valid,
    input wire [31:0] i_total_count,
    input wire [31:0] i_max_value,
    input wire [31:0] i_last_value,
    input wire [31:0] i_median_value
);

    `WLS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    `WLS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "second transaction taken while busy")

    `WLS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, i_out_valid && !i_stats_valid, i_total_count == 32'd0 && i_max_value == 32'd0 && i_last_value == 32'd0 && i_median_value == 32'd0, "empty result not zero")

    `WLS_ASSERT_IMP(a_peak_bound, i_clk, i_rst_n, i_out_valid && i_stats_valid, i_max_value >= i_last_value && i_max_value >= i_median_value, "peak below a window sample")

endmodule

bind windowed_latency_stats_core wls_checker u_wls_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_stats_valid  (o_out.stats_valid),
    .i_total_count  (o_out.total_count),
    .i_max_value    (o_out.max_value),
    .i_last_value   (o_out.last_value),
    .i_median_value (o_out.median_value)
);

`default_nettype wire

FILE: dv/windowed_latency_stats_core_tb.sv
`timescale 1ns / 1ps

module windowed_latency_stats_core_tb;
    import wls_pkg::*;

    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int NCH = 8;
    localparam int WD_LIMIT = 300000;  // covers a full-window median walk
    localparam int SMALL_FILL = 24;

    typedef struct {
        logic [1:0]  func;
        logic [2:0]  ch;
        logic [31:0] us;
        bit          hold;   // wait for all outstanding results before sending
    } stim_t;

    logic i_clk;
    logic i_rst_n;

    wls_in_if  in_if ();
    wls_out_if out_if ();

    windowed_latency_stats_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    stim_t   stim_q[$];
    t_result stats_q[$];

    // shadow copy of the block's per-channel state
    logic [31:0] ring[CHANNELS][WINDOW];
    int unsigned fill[CHANNELS];
    int unsigned wptr[CHANNELS];
    logic [31:0] total[CHANNELS];
    logic [31:0] peak[CHANNELS];
    logic [31:0] latest[CHANNELS];

    int gen_fill[NCH];
    int errors = 0;
    int n_results = 0;
    int n_record = 0, n_clear = 0, n_query = 0, n_other = 0;
    int wd_count = 0;
    int in_gap = 0, out_gap = 0;
    bit in_calm = 0, out_calm = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 7);       // forces ties
            3: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic void reset_channel(int c);
        fill[c] = 0;
        wptr[c] = 0;
        total[c] = '0;
        peak[c] = '0;
        latest[c] = '0;
    endfunction

    function automatic void stats_apply(stim_t s);
        t_result r;
        logic [31:0] win[$];
        int c;
        c = s.ch;
        if (s.func == FN_RECORD) begin
            n_record++;
            if (c < CHANNELS) begin
                ring[c][wptr[c]] = s.us;
                wptr[c] = (wptr[c] + 1) % WINDOW;
                if (fill[c] < WINDOW) fill[c]++;
                total[c] = total[c] + 32'd1;
                latest[c] = s.us;
                if (s.us > peak[c]) peak[c] = s.us;
            end
        end else if (s.func == FN_CLEAR) begin
            n_clear++;
            if (c < CHANNELS) reset_channel(c);
        end else if (s.func == FN_QUERY) begin
            n_query++;
            r = '0;
            if (c < CHANNELS) begin
                r.total_count = total[c];
                r.max_value = peak[c];
                r.last_value = latest[c];
                if (fill[c] > 0) begin
                    for (int i = 0; i < fill[c]; i++) win.push_back(ring[c][i]);
                    win.sort();
                    r.stats_valid = 1'b1;
                    r.median_value = win[fill[c] / 2];
                end
            end
            stats_q.push_back(r);
        end else begin
            n_other++;
        end
    endfunction

    function automatic void add(logic [1:0] f, int c, logic [31:0] v, bit h = 0);
        stim_t s;
        s.func = f;
        s.ch = 3'(c);
        s.us = v;
        s.hold = h;
        stim_q.push_back(s);
        if (c < CHANNELS) begin
            if (f == FN_RECORD) gen_fill[c]++;
            if (f == FN_CLEAR) gen_fill[c] = 0;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                stats_apply('{in_if.func, in_if.channel, in_if.sample_us, 1'b0});
                in_gap = pick_gap(in_calm);
                if ($urandom_range(99) == 0) in_calm = ~in_calm;
            end
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (stim_q.size() > 0 && (!stim_q[0].hold || stats_q.size() == 0)) begin
                    in_if.valid <= 1'b1;
                    in_if.func <= stim_q[0].func;
                    in_if.channel <= stim_q[0].ch;
                    in_if.sample_us <= stim_q[0].us;
                    void'(stim_q.pop_front());
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (stats_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result transaction at %0t", $realtime);
                end else begin
                    exp_r = stats_q.pop_front();
                    if (out_if.stats_valid !== exp_r.stats_valid
                        || out_if.total_count !== exp_r.total_count
                        || out_if.max_value !== exp_r.max_value
                        || out_if.last_value !== exp_r.last_value
                        || out_if.median_value !== exp_r.median_value) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch @%0t exp v=%0d cnt=%0h max=%0h last=%0h med=%0h got v=%0d cnt=%0h max=%0h last=%0h med=%0h",
                                     $realtime, exp_r.stats_valid, exp_r.total_count,
                                     exp_r.max_value, exp_r.last_value, exp_r.median_value,
                                     out_if.stats_valid, out_if.total_count, out_if.max_value,
                                     out_if.last_value, out_if.median_value);
                    end
                end
                out_gap = pick_gap(out_calm);
                if ($urandom_range(63) == 0) out_calm = ~out_calm;
            end
            if (out_gap > 0) begin
                out_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            wd_count <= 0;
        end else if (i_rst_n) begin
            wd_count <= wd_count + 1;
            if (wd_count >= WD_LIMIT) begin
                $display("watchdog expired");
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int c, r;
        in_if.valid = 1'b0;
        in_if.func = FN_RECORD;
        in_if.channel = '0;
        in_if.sample_us = '0;
        out_if.ready = 1'b0;
        for (int i = 0; i < CHANNELS; i++) reset_channel(i);
        for (int i = 0; i < NCH; i++) gen_fill[i] = 0;

        // directed
        add(FN_QUERY, 0, 0);                    // empty channel
        add(FN_QUERY, 7, 32'hFFFF_FFFF);        // out-of-range channel
        add(FN_RECORD, 7, 32'h1234_5678);       // ignored
        add(FN_CLEAR, 7, 0);                    // ignored
        add(FN_UNUSED, 0, 32'hFFFF_FFFF);       // ignored func
        add(FN_RECORD, 0, 32'd0);
        add(FN_RECORD, 0, 32'hFFFF_FFFF);
        add(FN_RECORD, 0, 32'd5);
        add(FN_QUERY, 0, 0);
        add(FN_RECORD, 1, 32'd7);
        add(FN_RECORD, 1, 32'd7);
        add(FN_QUERY, 1, 0);
        add(FN_RECORD, 6, 32'hAAAA_AAAA);
        add(FN_RECORD, 6, 32'h5555_5555);
        add(FN_QUERY, 6, 0);
        add(FN_CLEAR, 0, 0, 1);
        add(FN_QUERY, 0, 0);
        add(FN_QUERY, 7, 0);
        add(FN_QUERY, 3, 0);

        // random, fills kept small since a median walk is quadratic in fill
        for (int i = 0; i < 630; i++) begin
            r = $urandom_range(99);
            c = ($urandom_range(15) == 0) ? 7 : $urandom_range(CHANNELS - 1);
            if (r < 3)
                add(FN_UNUSED, c, $urandom);
            else if (r < 10 || (c < CHANNELS && gen_fill[c] >= SMALL_FILL))
                add(FN_CLEAR, c, $urandom);
            else if (r < 72)
                add(FN_RECORD, c, pick_sample());
            else
                add(FN_QUERY, c, $urandom, $urandom_range(29) == 0);
        end

        // one channel past a full window so the ring wraps
        add(FN_CLEAR, 5, 0, 1);
        for (int i = 0; i < WINDOW + 40; i++) begin
            add(FN_RECORD, 5, ($urandom_range(3) == 0) ? $urandom_range(0, 3) : $urandom);
            if (i == WINDOW - 1) add(FN_QUERY, 5, 0);
        end
        add(FN_QUERY, 5, 0);
        add(FN_RECORD, 5, 32'hFFFF_FFFF);
        add(FN_QUERY, 5, 0);

        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (stim_q.size() == 0);
        @(posedge i_clk);
        while (in_if.valid || stats_q.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("covered %0d records, %0d clears, %0d queries, %0d unused-func items",
                 n_record, n_clear, n_query, n_other);
        $display("%0d result transactions checked, %0d errors", n_results, errors);
        if (errors == 0 && stats_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
